// ===== design/assert_macros.svh =====
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/imhq_pkg.sv =====
// ----------------------------------------------------------------------------
// imhq_pkg
// Types and constants of the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;
  localparam int unsigned DefaultCapacity = 256;
  localparam int unsigned NumVertices = 256;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_PUSHED    = 2'd0,
    ST_POPPED    = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_PUSH_FULL = 2'd3
  } status_e;

  typedef struct packed {
    op_e               opcode;
    logic [7:0]        vertex_id;
    logic signed [63:0] priority_key;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_vertex;
    logic signed [63:0] out_key;
    status_e            status;
    logic [8:0]         entry_count;
    logic               is_empty;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_WR,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_MOVE,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic push_wr;
    logic up_rd;
    logic up_cmp;
    logic pop_rd;
    logic pop_move;
    logic dn_rdl;
    logic dn_rdr;
    logic dn_cmp;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic up_at_root;
    logic up_swap;
    logic dn_has_left;
    logic dn_has_right;
    logic dn_swap;
    logic cnt_zero;
  } sts_t;
endpackage

// ===== design/imhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// imhq_ctrl
// Sequencer of push sift-up and pop sift-down steps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module imhq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  imhq_pkg::op_e     opcode_i,
  input  imhq_pkg::sts_t    sts_i,
  output imhq_pkg::cmd_t    cmd_o,
  output logic              busy_o
);
  imhq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imhq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != imhq_pkg::S_IDLE);
    unique case (state_q)
      imhq_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (opcode_i == imhq_pkg::OP_PUSH) begin
            state_d = sts_i.full ? imhq_pkg::S_DONE : imhq_pkg::S_PUSH_WR;
          end else begin
            state_d = sts_i.empty ? imhq_pkg::S_DONE : imhq_pkg::S_POP_RD;
          end
        end
      end
      imhq_pkg::S_PUSH_WR: begin
        cmd_o.push_wr = 1'b1;
        state_d = imhq_pkg::S_UP_RD;
      end
      imhq_pkg::S_UP_RD: begin
        cmd_o.up_rd = 1'b1;
        state_d = sts_i.up_at_root ? imhq_pkg::S_DONE : imhq_pkg::S_UP_CMP;
      end
      imhq_pkg::S_UP_CMP: begin
        cmd_o.up_cmp = 1'b1;
        state_d = sts_i.up_swap ? imhq_pkg::S_UP_RD : imhq_pkg::S_DONE;
      end
      imhq_pkg::S_POP_RD: begin
        cmd_o.pop_rd = 1'b1;
        state_d = imhq_pkg::S_POP_MOVE;
      end
      imhq_pkg::S_POP_MOVE: begin
        cmd_o.pop_move = 1'b1;
        state_d = sts_i.cnt_zero ? imhq_pkg::S_DONE : imhq_pkg::S_DN_RDL;
      end
      imhq_pkg::S_DN_RDL: begin
        cmd_o.dn_rdl = 1'b1;
        state_d = sts_i.dn_has_left ? imhq_pkg::S_DN_RDR : imhq_pkg::S_DONE;
      end
      imhq_pkg::S_DN_RDR: begin
        cmd_o.dn_rdr = 1'b1;
        state_d = imhq_pkg::S_DN_CMP;
      end
      imhq_pkg::S_DN_CMP: begin
        cmd_o.dn_cmp = 1'b1;
        state_d = sts_i.dn_swap ? imhq_pkg::S_DN_RDL : imhq_pkg::S_DONE;
      end
      imhq_pkg::S_DONE: begin
        cmd_o.done = 1'b1;
        state_d = imhq_pkg::S_IDLE;
      end
      default: state_d = imhq_pkg::S_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_load_idle, cmd_o.load, state_q == imhq_pkg::S_IDLE, "load outside idle")
  `ASSERT_NEXT(a_done_idle, cmd_o.done, state_q == imhq_pkg::S_IDLE, "done not followed by idle")
  `ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0(cmd_o), "multiple commands")
endmodule

// ===== design/imhq_dp.sv =====
// ----------------------------------------------------------------------------
// imhq_dp
// Heap entry memory, position map, count and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module imhq_dp #(
  parameter int unsigned Capacity = imhq_pkg::DefaultCapacity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  imhq_pkg::in_item_t  in_i,
  input  imhq_pkg::cmd_t      cmd_i,
  output imhq_pkg::sts_t      sts_o,
  output imhq_pkg::out_item_t res_o,
  output logic                res_valid_o
);
  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned VW = 8;
  localparam int unsigned EW = 64 + VW;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  logic [EW-1:0] mem_q [Capacity];
  logic [AW:0]   pos_q [imhq_pkg::NumVertices];
  logic [imhq_pkg::NumVertices-1:0] pos_vld_q, pos_vld_d;

  cnt_t  cnt_q;
  addr_t slot_q;
  logic  full_q;
  logic [EW-1:0] cur_q, oth_q, lft_q, rd_q;
  logic [EW-1:0] new_q;
  logic [EW-1:0] root_q;
  logic root_vld_q;
  imhq_pkg::in_item_t inq_q;
  imhq_pkg::out_item_t res_q;
  logic res_vld_q;
  logic rd_en, wr_en, wr2_en;
  addr_t rd_addr, wr_addr, wr2_addr;
  logic [EW-1:0] wr_data, wr2_data;

  addr_t parent, left_a, right_a;
  cnt_t left_c, right_c;
  logic up_less, dn_l_less, dn_r_less;
  logic [63:0] best_key;

  function automatic logic key_lt(logic [63:0] a, logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction

  assign parent  = AW'((cnt_t'(slot_q) - cnt_t'(1)) >> 1);
  assign left_c  = cnt_t'({slot_q, 1'b1});
  assign right_c = left_c + cnt_t'(1);
  assign left_a  = AW'(left_c);
  assign right_a = AW'(right_c);

  assign up_less   = key_lt(cur_q[EW-1:VW], rd_q[EW-1:VW]);
  assign dn_l_less = key_lt(lft_q[EW-1:VW], cur_q[EW-1:VW]);
  assign best_key  = dn_l_less ? lft_q[EW-1:VW] : cur_q[EW-1:VW];
  assign dn_r_less = (right_c < cnt_q) && key_lt(rd_q[EW-1:VW], best_key);

  always_comb begin
    sts_o = '0;
    sts_o.full  = (cnt_q == cnt_t'(Capacity));
    sts_o.empty = (cnt_q == '0);
    sts_o.up_at_root = (slot_q == '0);
    sts_o.up_swap = up_less;
    sts_o.dn_has_left = (left_c < cnt_q) && (cnt_t'(slot_q) < cnt_t'(Capacity / 2));
    sts_o.dn_has_right = right_c < cnt_q;
    sts_o.dn_swap = dn_l_less || dn_r_less;
    sts_o.cnt_zero = (cnt_q == '0);
  end

  always_comb begin
    rd_en = 1'b0; rd_addr = '0;
    wr_en = 1'b0; wr_addr = '0; wr_data = '0;
    wr2_en = 1'b0; wr2_addr = '0; wr2_data = '0;
    if (cmd_i.up_rd) begin
      rd_en = 1'b1; rd_addr = parent;
    end
    if (cmd_i.pop_rd) begin
      rd_en = 1'b1; rd_addr = AW'(cnt_q - cnt_t'(1));
    end
    if (cmd_i.dn_rdl) begin
      rd_en = 1'b1; rd_addr = left_a;
    end
    if (cmd_i.dn_rdr) begin
      rd_en = 1'b1; rd_addr = right_a;
    end
    if (cmd_i.push_wr) begin
      wr_en = 1'b1; wr_addr = slot_q; wr_data = new_q;
    end
    if (cmd_i.up_cmp && up_less) begin
      wr_en = 1'b1; wr_addr = slot_q; wr_data = rd_q;
      wr2_en = 1'b1; wr2_addr = parent; wr2_data = cur_q;
    end
    if (cmd_i.pop_move && cnt_q != '0) begin
      wr_en = 1'b1; wr_addr = '0; wr_data = rd_q;
    end
    if (cmd_i.dn_cmp && (dn_l_less || dn_r_less)) begin
      wr_en = 1'b1; wr_addr = slot_q; wr_data = dn_r_less ? rd_q : lft_q;
      wr2_en = 1'b1; wr2_addr = dn_r_less ? right_a : left_a; wr2_data = cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (wr2_en) mem_q[wr2_addr] <= wr2_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      inq_q <= in_i;
      new_q <= {in_i.priority_key, in_i.vertex_id};
      slot_q <= AW'(cnt_q);
      full_q <= sts_o.full;
    end
    if (cmd_i.push_wr) cur_q <= new_q;
    if (cmd_i.up_cmp && up_less) slot_q <= parent;
    if (cmd_i.pop_move) begin
      cur_q <= rd_q;
      slot_q <= '0;
    end
    if (cmd_i.dn_rdl) lft_q <= '0;
    if (cmd_i.dn_rdr) lft_q <= rd_q;
    if (cmd_i.dn_cmp && (dn_l_less || dn_r_less)) slot_q <= dn_r_less ? right_a : left_a;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_rd) root_q <= mem_q[0];
  end

  always_comb begin
    pos_vld_d = pos_vld_q;
    if (cmd_i.push_wr) pos_vld_d[new_q[VW-1:0]] = 1'b1;
    if (cmd_i.pop_move) begin
      pos_vld_d[root_q[VW-1:0]] = 1'b0;
      if (cnt_q != '0) pos_vld_d[rd_q[VW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_vld_q <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= cmd_i.done;
      pos_vld_q <= pos_vld_d;
      if (cmd_i.push_wr) cnt_q <= cnt_q + cnt_t'(1);
      if (cmd_i.pop_rd) cnt_q <= cnt_q - cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_wr) pos_q[new_q[VW-1:0]] <= (AW+1)'(slot_q);
    if (cmd_i.up_cmp && up_less) begin
      pos_q[cur_q[VW-1:0]] <= (AW+1)'(parent);
      pos_q[rd_q[VW-1:0]] <= (AW+1)'(slot_q);
    end
    if (cmd_i.pop_move && cnt_q != '0) pos_q[rd_q[VW-1:0]] <= '0;
    if (cmd_i.dn_cmp && (dn_l_less || dn_r_less)) begin
      pos_q[dn_r_less ? rd_q[VW-1:0] : lft_q[VW-1:0]] <= (AW+1)'(slot_q);
      pos_q[cur_q[VW-1:0]] <= (AW+1)'(dn_r_less ? right_a : left_a);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      res_q.entry_count <= 9'(cnt_q);
      res_q.is_empty    <= (cnt_q == '0);
      if (inq_q.opcode == imhq_pkg::OP_PUSH) begin
        res_q.out_vertex <= '0;
        res_q.out_key    <= '0;
        res_q.status     <= full_q ? imhq_pkg::ST_PUSH_FULL : imhq_pkg::ST_PUSHED;
      end else if (root_vld_q) begin
        res_q.out_vertex <= root_q[VW-1:0];
        res_q.out_key    <= root_q[EW-1:VW];
        res_q.status     <= imhq_pkg::ST_POPPED;
      end else begin
        res_q.out_vertex <= '0;
        res_q.out_key    <= '0;
        res_q.status     <= imhq_pkg::ST_POP_EMPTY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_vld_q <= 1'b0;
    end else if (cmd_i.load) begin
      root_vld_q <= 1'b0;
    end else if (cmd_i.pop_rd) begin
      root_vld_q <= 1'b1;
    end
  end

  assign res_o = res_q;
  assign res_valid_o = res_vld_q;

  `ASSERT_NEXT(a_push_cnt, cmd_i.push_wr, cnt_q == $past(cnt_q) + cnt_t'(1), "push count")
  `ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= cnt_t'(Capacity), "count overflow")
  `ASSERT_IMPL(a_pop_nonempty, cmd_i.pop_rd, cnt_q != '0, "pop on empty")
endmodule

// ===== design/indexed_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap of vertex/key entries with push and pop-minimum.
// ----------------------------------------------------------------------------
// A push loads, writes the new entry at the end, then per level reads the parent and
// compares, climbing until the root or no swap; a pop loads, reads the last entry, moves
// it to the root unless the heap is now empty, then per level reads the left child, reads
// the right child and compares; a flagged full push or empty pop goes from load straight
// to done. One operation at a time; start is taken again in the strobe cycle.
// Reset clears count and state; entries are undefined until written; no receiver stall.
module indexed_min_heap_queue #(
  parameter int unsigned Capacity = imhq_pkg::DefaultCapacity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  imhq_pkg::in_item_t  in_item_i,
  output logic                result_valid_o,
  output imhq_pkg::out_item_t result_o
);
  imhq_pkg::cmd_t cmd;
  imhq_pkg::sts_t sts;

  imhq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (in_item_i.opcode),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  imhq_dp #(.Capacity(Capacity)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (result_o),
    .res_valid_o (result_valid_o)
  );
endmodule

// ===== tb/indexed_min_heap_queue_test.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_test
// Drives push and pop commands into the indexed min-heap queue, predicts every
// result with a behavioral heap model and compares each result field by field.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap = imhq_pkg::DefaultCapacity;
  localparam int LimitCycles = 400000;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  imhq_pkg::in_item_t  in_item_i;
  logic                result_valid_o;
  imhq_pkg::out_item_t result_o;

  indexed_min_heap_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .in_item_i     (in_item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  logic signed [63:0] pq_keys[Cap];
  logic [7:0]         pq_verts[Cap];
  int                 pq_pos[imhq_pkg::NumVertices];
  int                 pq_count;

  imhq_pkg::in_item_t  cmd_queue[$];
  imhq_pkg::out_item_t result_queue[$];
  int        idle_pct;
  int        error_count;
  int        cycle_count;
  bit        stim_done;

  function automatic void pq_swap(int a, int b);
    logic signed [63:0] k;
    logic [7:0]         v;
    k = pq_keys[a]; v = pq_verts[a];
    pq_keys[a] = pq_keys[b]; pq_verts[a] = pq_verts[b];
    pq_keys[b] = k; pq_verts[b] = v;
    pq_pos[pq_verts[a]] = a;
    pq_pos[pq_verts[b]] = b;
  endfunction

  function automatic imhq_pkg::out_item_t pq_apply(imhq_pkg::in_item_t it);
    imhq_pkg::out_item_t r;
    int s, p, l, rt, best;
    r = '0;
    if (it.opcode == imhq_pkg::OP_PUSH) begin
      if (pq_count >= Cap) begin
        r.status = imhq_pkg::ST_PUSH_FULL;
      end else begin
        s = pq_count;
        pq_keys[s] = it.priority_key;
        pq_verts[s] = it.vertex_id;
        pq_pos[it.vertex_id] = s;
        pq_count++;
        while (s > 0) begin
          p = (s - 1) / 2;
          if (!(pq_keys[s] < pq_keys[p])) break;
          pq_swap(p, s);
          s = p;
        end
        r.status = imhq_pkg::ST_PUSHED;
      end
    end else begin
      if (pq_count == 0) begin
        r.status = imhq_pkg::ST_POP_EMPTY;
      end else begin
        r.out_vertex = pq_verts[0];
        r.out_key = pq_keys[0];
        pq_pos[pq_verts[0]] = -1;
        pq_count--;
        if (pq_count > 0) begin
          pq_keys[0] = pq_keys[pq_count];
          pq_verts[0] = pq_verts[pq_count];
          pq_pos[pq_verts[0]] = 0;
          s = 0;
          forever begin
            l = 2 * s + 1; rt = 2 * s + 2; best = s;
            if (l < pq_count && pq_keys[l] < pq_keys[best]) best = l;
            if (rt < pq_count && pq_keys[rt] < pq_keys[best]) best = rt;
            if (best == s) break;
            pq_swap(s, best);
            s = best;
          end
        end
        r.status = imhq_pkg::ST_POPPED;
      end
    end
    r.entry_count = pq_count[8:0];
    r.is_empty = (pq_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic logic signed [63:0] rand_key();
    logic signed [63:0] k;
    case ($urandom_range(0, 5))
      0: k = 64'sh8000_0000_0000_0000;
      1: k = 64'sh7fff_ffff_ffff_ffff;
      2: k = $signed(64'($urandom_range(0, 7)) - 64'd3);
      default: k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  function automatic imhq_pkg::in_item_t mk(imhq_pkg::op_e op, logic [7:0] v,
                                            logic signed [63:0] k);
    imhq_pkg::in_item_t it;
    it.opcode = op; it.vertex_id = v; it.priority_key = k;
    return it;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      in_item_i <= '0;
    end else if (!(start && busy)) begin
      if (start) begin
        result_queue.push_back(pq_apply(in_item_i));
      end
      if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        in_item_i <= cmd_queue.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    imhq_pkg::out_item_t want;
    if (rst_ni && result_valid_o) begin
      if (result_queue.size() == 0) begin
        report_mismatch("unexpected transfer", 64'(result_o), 64'd0);
      end else begin
        want = result_queue.pop_front();
        if (result_o.out_vertex !== want.out_vertex)
          report_mismatch("out_vertex", 64'(result_o.out_vertex), 64'(want.out_vertex));
        if (result_o.out_key !== want.out_key)
          report_mismatch("out_key", result_o.out_key, want.out_key);
        if (result_o.status !== want.status)
          report_mismatch("status", 64'(result_o.status), 64'(want.status));
        if (result_o.entry_count !== want.entry_count)
          report_mismatch("entry_count", 64'(result_o.entry_count), 64'(want.entry_count));
        if (result_o.is_empty !== want.is_empty)
          report_mismatch("is_empty", 64'(result_o.is_empty), 64'(want.is_empty));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("** indexed_min_heap_queue: FAILED **");
      $finish;
    end
  end

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || start || result_queue.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int phase, n, depth;
    cycle_count = 0;
    error_count = 0;
    idle_pct = 0;
    for (int i = 0; i < imhq_pkg::NumVertices; i++) pq_pos[i] = -1;
    pq_count = 0;
    @(posedge rst_ni);

    cmd_queue.push_back(mk(imhq_pkg::OP_POP, 8'hff, 64'sh7fff_ffff_ffff_ffff));
    cmd_queue.push_back(mk(imhq_pkg::OP_PUSH, 8'h00, 64'sh7fff_ffff_ffff_ffff));
    cmd_queue.push_back(mk(imhq_pkg::OP_PUSH, 8'hff, 64'sh8000_0000_0000_0000));
    cmd_queue.push_back(mk(imhq_pkg::OP_PUSH, 8'h55, 64'sh0));
    cmd_queue.push_back(mk(imhq_pkg::OP_PUSH, 8'haa, 64'sh0));
    cmd_queue.push_back(mk(imhq_pkg::OP_PUSH, 8'h55, -64'sh1));
    cmd_queue.push_back(mk(imhq_pkg::OP_PUSH, 8'h12, 64'sh0));
    for (int i = 0; i < 7; i++) cmd_queue.push_back(mk(imhq_pkg::OP_POP, 8'h00, 64'sh0));
    for (int i = 0; i < 4; i++)
      cmd_queue.push_back(mk(imhq_pkg::OP_PUSH, 8'(i), 64'sh5));
    for (int i = 0; i < 4; i++) cmd_queue.push_back(mk(imhq_pkg::OP_POP, 8'h0, 64'sh0));
    wait_drained();

    // fill to capacity, overflow, drain past empty
    idle_pct = 52;
    for (int i = 0; i < Cap + 2; i++)
      cmd_queue.push_back(mk(imhq_pkg::OP_PUSH, 8'($urandom), rand_key()));
    for (int i = 0; i < Cap + 2; i++)
      cmd_queue.push_back(mk(imhq_pkg::OP_POP, 8'h0, 64'sh0));
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 52 : (phase == 3) ? 19 : 0;
      n = 0;
      while (n < 60) begin
        depth = $urandom_range(1, 12);
        for (int i = 0; i < depth; i++) begin
          cmd_queue.push_back(mk(($urandom_range(0, 3) == 0) ? imhq_pkg::OP_POP
                                                             : imhq_pkg::OP_PUSH,
                                 8'($urandom), rand_key()));
          n++;
        end
        for (int i = 0; i < $urandom_range(0, depth); i++) begin
          cmd_queue.push_back(mk(imhq_pkg::OP_POP, 8'($urandom), rand_key()));
          n++;
        end
      end
      wait_drained();
    end
    repeat (40) @(posedge clk_i);

    if (error_count == 0 && result_queue.size() == 0) begin
      $display("** indexed_min_heap_queue: PASSED **");
    end else begin
      $display("** indexed_min_heap_queue: FAILED **");
    end
    $finish;
  end
endmodule

// ===== indexed_min_heap_queue.f =====
+incdir+design
design/imhq_pkg.sv
design/imhq_ctrl.sv
design/imhq_dp.sv
design/indexed_min_heap_queue.sv
tb/indexed_min_heap_queue_test.sv
